// ===== hw/rtl/rvenc_pkg.sv =====
// ----------------------------------------------------------------------------
// rvenc_pkg
// Shared types, operation codes and encoding tables for the RV32IM encoder.
// ----------------------------------------------------------------------------
package rvenc_pkg;

   typedef struct packed {
      logic        [5:0]  mode;
      logic        [4:0]  dest_reg;
      logic        [4:0]  src1_reg;
      logic        [4:0]  src2_reg;
      logic signed [31:0] immediate;
   } req_type;

   typedef struct packed {
      logic [31:0] instr_word;
      logic        range_error;
   } rsp_type;

   typedef enum logic [2:0] {
      FMT_R,
      FMT_I,
      FMT_S,
      FMT_B,
      FMT_J,
      FMT_U,
      FMT_FIXED,
      FMT_NONE
   } fmt_type;

   typedef enum logic [5:0] {
      OP_ADD, OP_SUB, OP_XOR, OP_OR, OP_AND, OP_SLL, OP_SRL, OP_SRA, OP_SLT, OP_SLTU,
      OP_ADDI, OP_XORI, OP_ORI, OP_ANDI, OP_SLLI, OP_SRLI, OP_SRAI, OP_SLTI, OP_SLTIU,
      OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU,
      OP_SB, OP_SH, OP_SW,
      OP_BEQ, OP_BNE, OP_BLT, OP_BGE, OP_BLTU, OP_BGEU,
      OP_JAL, OP_JALR,
      OP_LUI, OP_AUIPC,
      OP_ECALL, OP_EBREAK,
      OP_MUL, OP_DIV, OP_REM
   } op_type;

   function automatic fmt_type op_format(input op_type op);
      fmt_type f;
      case (op)
         OP_ADD, OP_SUB, OP_XOR, OP_OR, OP_AND, OP_SLL, OP_SRL, OP_SRA, OP_SLT,
         OP_SLTU, OP_MUL, OP_DIV, OP_REM: begin
            f = FMT_R;
         end
         OP_ADDI, OP_XORI, OP_ORI, OP_ANDI, OP_SLLI, OP_SRLI, OP_SRAI, OP_SLTI,
         OP_SLTIU, OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU, OP_JALR: begin
            f = FMT_I;
         end
         OP_SB, OP_SH, OP_SW: begin
            f = FMT_S;
         end
         OP_BEQ, OP_BNE, OP_BLT, OP_BGE, OP_BLTU, OP_BGEU: begin
            f = FMT_B;
         end
         OP_JAL: begin
            f = FMT_J;
         end
         OP_LUI, OP_AUIPC: begin
            f = FMT_U;
         end
         OP_ECALL, OP_EBREAK: begin
            f = FMT_FIXED;
         end
         default: begin
            f = FMT_NONE;
         end
      endcase
      return f;
   endfunction

   function automatic logic [31:0] base_word(input op_type op);
      logic [31:0] w;
      case (op)
         OP_ADD:    w = 32'h0000_0033;
         OP_SUB:    w = 32'h4000_0033;
         OP_XOR:    w = 32'h0000_4033;
         OP_OR:     w = 32'h0000_6033;
         OP_AND:    w = 32'h0000_7033;
         OP_SLL:    w = 32'h0000_1033;
         OP_SRL:    w = 32'h0000_5033;
         OP_SRA:    w = 32'h4000_5033;
         OP_SLT:    w = 32'h0000_2033;
         OP_SLTU:   w = 32'h0000_3033;
         OP_ADDI:   w = 32'h0000_0013;
         OP_XORI:   w = 32'h0000_4013;
         OP_ORI:    w = 32'h0000_6013;
         OP_ANDI:   w = 32'h0000_7013;
         OP_SLLI:   w = 32'h0000_1013;
         OP_SRLI:   w = 32'h0000_5013;
         OP_SRAI:   w = 32'h4000_5013;
         OP_SLTI:   w = 32'h0000_2013;
         OP_SLTIU:  w = 32'h0000_3013;
         OP_LB:     w = 32'h0000_0003;
         OP_LH:     w = 32'h0000_1003;
         OP_LW:     w = 32'h0000_2003;
         OP_LBU:    w = 32'h0000_4003;
         OP_LHU:    w = 32'h0000_5003;
         OP_SB:     w = 32'h0000_0023;
         OP_SH:     w = 32'h0000_1023;
         OP_SW:     w = 32'h0000_2023;
         OP_BEQ:    w = 32'h0000_0063;
         OP_BNE:    w = 32'h0000_1063;
         OP_BLT:    w = 32'h0000_4063;
         OP_BGE:    w = 32'h0000_5063;
         OP_BLTU:   w = 32'h0000_6063;
         OP_BGEU:   w = 32'h0000_7063;
         OP_JAL:    w = 32'h0000_006F;
         OP_JALR:   w = 32'h0000_0067;
         OP_LUI:    w = 32'h0000_0037;
         OP_AUIPC:  w = 32'h0000_0017;
         OP_ECALL:  w = 32'h0000_0073;
         OP_EBREAK: w = 32'h0010_0073;
         OP_MUL:    w = 32'h0200_0033;
         OP_DIV:    w = 32'h0200_4033;
         OP_REM:    w = 32'h0200_6033;
         default:   w = 32'h0000_0000;
      endcase
      return w;
   endfunction

endpackage

// ===== hw/rtl/rvenc_encode.sv =====
// ----------------------------------------------------------------------------
// rvenc_encode
// Field packing and immediate range check for one registered request.
// ----------------------------------------------------------------------------
module rvenc_encode (
   input  rvenc_pkg::req_type req,
   output rvenc_pkg::rsp_type rsp
);
   import rvenc_pkg::*;

   op_type      op;
   fmt_type     fmt;
   logic [31:0] base;
   logic [31:0] imm;
   logic [31:0] rd_f;
   logic [31:0] rs1_f;
   logic [31:0] rs2_f;
   logic [31:0] rd_hi_f;
   logic [31:0] i_imm;
   logic [31:0] s_imm;
   logic [31:0] b_imm;
   logic [31:0] j_imm;
   logic [31:0] u_imm;
   logic        i_ok;
   logic        b_ok;

   assign op   = op_type'(req.mode);
   assign fmt  = op_format(op);
   assign base = base_word(op);
   assign imm  = req.immediate;

   assign rd_f    = {20'b0, req.dest_reg, 7'b0};
   assign rs1_f   = {12'b0, req.src1_reg, 15'b0};
   assign rs2_f   = {7'b0, req.src2_reg, 20'b0};
   assign rd_hi_f = {7'b0, req.dest_reg, 20'b0};

   assign i_imm = {imm[11:0], 20'b0};
   assign s_imm = {imm[11:5], 13'b0, imm[4:0], 7'b0};
   assign b_imm = {imm[31], imm[10:5], 13'b0, imm[4:1], imm[11], 7'b0};
   assign j_imm = {imm[31], imm[10:1], imm[11], imm[19:12], 12'b0};
   assign u_imm = {imm[31:12], 12'b0};

   // -2048..2047 and -4096..4095: upper bits all copies of the sign
   assign i_ok = (imm[31:11] == '0) || (imm[31:11] == '1);
   assign b_ok = (imm[31:12] == '0) || (imm[31:12] == '1);

   always_comb begin
      rsp.instr_word  = 32'h0;
      rsp.range_error = 1'b0;
      case (fmt)
         FMT_R: begin
            rsp.instr_word = base + rd_f + rs1_f + rs2_f;
         end
         FMT_I: begin
            if (i_ok) begin
               rsp.instr_word = base + rd_f + rs1_f + i_imm;
            end else begin
               rsp.range_error = 1'b1;
            end
         end
         FMT_S: begin
            if (i_ok) begin
               rsp.instr_word = base + rs1_f + rd_hi_f + s_imm;
            end else begin
               rsp.range_error = 1'b1;
            end
         end
         FMT_B: begin
            if (b_ok) begin
               rsp.instr_word = base + rs1_f + rs2_f + b_imm;
            end else begin
               rsp.range_error = 1'b1;
            end
         end
         FMT_J: begin
            rsp.instr_word = base + rd_f + j_imm;
         end
         FMT_U: begin
            rsp.instr_word = base + rd_f + u_imm;
         end
         FMT_FIXED: begin
            rsp.instr_word = base;
         end
         default: begin
            rsp.instr_word = 32'h0;
         end
      endcase
   end

endmodule

// ===== hw/rtl/rv32im_instruction_encoder_top.sv =====
// ----------------------------------------------------------------------------
// rv32im_instruction_encoder_top
// RV32IM instruction encoder: operation, registers and immediate in,
// 32-bit instruction word and range error flag out.
//
//   channel   handshake          payload
//   request   start / busy       req_data  (req_type)
//   response  rsp_valid strobe   rsp_data  (rsp_type)
//
// One item per cycle; busy is never raised. Each request is captured in the
// request register, then passes through the encode logic into the response
// register. rsp_valid is high for exactly one cycle per item. Synchronous
// reset clears both valid flags.
// ----------------------------------------------------------------------------
module rv32im_instruction_encoder_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  rvenc_pkg::req_type req_data,
   output logic               rsp_valid,
   output rvenc_pkg::rsp_type rsp_data
);
   import rvenc_pkg::*;

   req_type req_ff;
   logic    req_valid_ff;
   logic    req_valid_in;
   rsp_type rsp_in;
   rsp_type rsp_ff;
   logic    rsp_valid_ff;

   assign busy         = 1'b0;
   assign req_valid_in = start & ~busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid_in) begin
         req_ff <= req_data;
      end
      if (req_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   rvenc_encode u_encode (
      .req (req_ff),
      .rsp (rsp_in)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== tb/sv/tb_rv32im_instruction_encoder_top.sv =====
// ----------------------------------------------------------------------------
// tb_rv32im_instruction_encoder_top
// Self-checking testbench for the RV32IM instruction encoder. A directed set
// hits the immediate range limits of the I, S and B layouts, the wrapping jump offset,
// the fixed system words and undefined selectors. Random items then follow in
// phases with and without request gaps. Each accepted item is encoded by an
// independent model; word and range error flag are compared with the response stream.
// ----------------------------------------------------------------------------
module tb_rv32im_instruction_encoder_top;
   timeunit 1ns;
   timeprecision 1ps;

   import rvenc_pkg::*;

   localparam int unsigned ITEMS_PER_PHASE = 670;
   localparam int unsigned STALL_LIMIT     = 1000;
   localparam int unsigned MAX_PRINTED     = 40;

   typedef struct {
      req_type req;
      rsp_type rsp;
   } encode_record;

   class encoder_scoreboard;
      encode_record pending[$];
      int unsigned  errors;
      int unsigned  encoded;
      int unsigned  range_errors;
      bit [63:0]    selectors_seen;

      function fmt_type layout_of(input logic [5:0] sel);
         fmt_type f;
         if (sel > OP_REM) begin
            f = FMT_NONE;
         end else begin
            case (op_type'(sel))
               OP_ADDI, OP_XORI, OP_ORI, OP_ANDI, OP_SLLI, OP_SRLI, OP_SRAI, OP_SLTI,
               OP_SLTIU, OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU, OP_JALR: f = FMT_I;
               OP_SB, OP_SH, OP_SW: f = FMT_S;
               OP_BEQ, OP_BNE, OP_BLT, OP_BGE, OP_BLTU, OP_BGEU: f = FMT_B;
               OP_JAL: f = FMT_J;
               OP_LUI, OP_AUIPC: f = FMT_U;
               OP_ECALL, OP_EBREAK: f = FMT_FIXED;
               default: f = FMT_R;
            endcase
         end
         return f;
      endfunction

      // opcode, funct3 and funct7 of each operation
      function logic [31:0] fixed_bits(input logic [5:0] sel);
         logic [6:0] opc;
         logic [2:0] f3;
         logic [6:0] f7;
         opc = 7'h00;
         f3  = 3'd0;
         f7  = 7'h00;
         if (sel <= OP_REM) begin
            case (op_type'(sel))
               OP_ADD:    opc = 7'h33;
               OP_SUB:    begin opc = 7'h33; f7 = 7'h20; end
               OP_XOR:    begin opc = 7'h33; f3 = 3'd4; end
               OP_OR:     begin opc = 7'h33; f3 = 3'd6; end
               OP_AND:    begin opc = 7'h33; f3 = 3'd7; end
               OP_SLL:    begin opc = 7'h33; f3 = 3'd1; end
               OP_SRL:    begin opc = 7'h33; f3 = 3'd5; end
               OP_SRA:    begin opc = 7'h33; f3 = 3'd5; f7 = 7'h20; end
               OP_SLT:    begin opc = 7'h33; f3 = 3'd2; end
               OP_SLTU:   begin opc = 7'h33; f3 = 3'd3; end
               OP_MUL:    begin opc = 7'h33; f7 = 7'h01; end
               OP_DIV:    begin opc = 7'h33; f3 = 3'd4; f7 = 7'h01; end
               OP_REM:    begin opc = 7'h33; f3 = 3'd6; f7 = 7'h01; end
               OP_ADDI:   opc = 7'h13;
               OP_XORI:   begin opc = 7'h13; f3 = 3'd4; end
               OP_ORI:    begin opc = 7'h13; f3 = 3'd6; end
               OP_ANDI:   begin opc = 7'h13; f3 = 3'd7; end
               OP_SLLI:   begin opc = 7'h13; f3 = 3'd1; end
               OP_SRLI:   begin opc = 7'h13; f3 = 3'd5; end
               OP_SRAI:   begin opc = 7'h13; f3 = 3'd5; f7 = 7'h20; end
               OP_SLTI:   begin opc = 7'h13; f3 = 3'd2; end
               OP_SLTIU:  begin opc = 7'h13; f3 = 3'd3; end
               OP_LB:     opc = 7'h03;
               OP_LH:     begin opc = 7'h03; f3 = 3'd1; end
               OP_LW:     begin opc = 7'h03; f3 = 3'd2; end
               OP_LBU:    begin opc = 7'h03; f3 = 3'd4; end
               OP_LHU:    begin opc = 7'h03; f3 = 3'd5; end
               OP_SB:     opc = 7'h23;
               OP_SH:     begin opc = 7'h23; f3 = 3'd1; end
               OP_SW:     begin opc = 7'h23; f3 = 3'd2; end
               OP_BEQ:    opc = 7'h63;
               OP_BNE:    begin opc = 7'h63; f3 = 3'd1; end
               OP_BLT:    begin opc = 7'h63; f3 = 3'd4; end
               OP_BGE:    begin opc = 7'h63; f3 = 3'd5; end
               OP_BLTU:   begin opc = 7'h63; f3 = 3'd6; end
               OP_BGEU:   begin opc = 7'h63; f3 = 3'd7; end
               OP_JAL:    opc = 7'h6F;
               OP_JALR:   opc = 7'h67;
               OP_LUI:    opc = 7'h37;
               OP_AUIPC:  opc = 7'h17;
               default:   opc = 7'h73;
            endcase
         end
         return {f7, 10'b0, f3, 5'b0, opc};
      endfunction

      // all fields are summed, so srai's funct7 bit carries into the immediate
      function rsp_type encode_instr(input req_type r);
         rsp_type             e;
         logic [31:0]         u;
         logic signed [31:0]  v;
         logic [31:0]         w;
         u = r.immediate;
         v = r.immediate;
         w = fixed_bits(r.mode);
         e.range_error = 1'b0;
         case (layout_of(r.mode))
            FMT_R: w = w + {r.dest_reg, 7'b0} + {r.src1_reg, 15'b0} + {r.src2_reg, 20'b0};
            FMT_I: begin
               if (v > 2047 || v < -2048) e.range_error = 1'b1;
               w = w + {r.dest_reg, 7'b0} + {r.src1_reg, 15'b0} + {u[11:0], 20'b0};
            end
            FMT_S: begin
               if (v > 2047 || v < -2048) e.range_error = 1'b1;
               w = w + {r.src1_reg, 15'b0} + {r.dest_reg, 20'b0} + {u[4:0], 7'b0}
                     + {u[11:5], 25'b0};
            end
            FMT_B: begin
               if (v > 4095 || v < -4096) e.range_error = 1'b1;
               w = w + {r.src1_reg, 15'b0} + {r.src2_reg, 20'b0} + {u[11], 7'b0}
                     + {u[4:1], 8'b0} + {u[10:5], 25'b0} + {u[31], 31'b0};
            end
            FMT_J: w = w + {r.dest_reg, 7'b0} + {u[10:1], 21'b0} + {u[11], 20'b0}
                         + {u[19:12], 12'b0} + {u[31], 31'b0};
            FMT_U: w = w + {r.dest_reg, 7'b0} + {u[31:12], 12'b0};
            FMT_FIXED: begin
               if (op_type'(r.mode) == OP_EBREAK) w = w + 32'h0010_0000;
            end
            default: w = 32'h0;
         endcase
         e.instr_word = e.range_error ? 32'h0 : w;
         return e;
      endfunction

      function void note_request(input req_type r);
         encode_record rec;
         rec.req = r;
         rec.rsp = encode_instr(r);
         selectors_seen[r.mode] = 1'b1;
         pending.push_back(rec);
      endfunction

      task report_mismatch(input string msg);
         errors++;
         if (errors <= MAX_PRINTED) $display("[%0t] MISMATCH %s", $time, msg);
      endtask

      task check_result(input rsp_type got);
         encode_record rec;
         if (pending.size() == 0) begin
            report_mismatch($sformatf("unexpected result word=%08h err=%0b",
                                      got.instr_word, got.range_error));
         end else begin
            rec = pending.pop_front();
            encoded++;
            if (rec.rsp.range_error) range_errors++;
            if (got.instr_word !== rec.rsp.instr_word)
               report_mismatch($sformatf("mode=%0d rd=%0d rs1=%0d rs2=%0d imm=%0d word %08h exp %08h",
                  rec.req.mode, rec.req.dest_reg, rec.req.src1_reg, rec.req.src2_reg,
                  rec.req.immediate, got.instr_word, rec.rsp.instr_word));
            if (got.range_error !== rec.rsp.range_error)
               report_mismatch($sformatf("mode=%0d imm=%0d range_error %0b exp %0b",
                  rec.req.mode, rec.req.immediate, got.range_error, rec.rsp.range_error));
         end
      endtask
   endclass

   logic    clock = 1'b0;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   encoder_scoreboard sb = new();
   int unsigned       quiet_cycles;

   rv32im_instruction_encoder_top dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) sb.note_request(req_data);
         if (rsp_valid) sb.check_result(rsp_data);
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic req_type make_req(input logic [5:0] sel, input logic [4:0] rd,
                                        input logic [4:0] rs1, input logic [4:0] rs2,
                                        input int imm);
      req_type r;
      r.mode      = sel;
      r.dest_reg  = rd;
      r.src1_reg  = rs1;
      r.src2_reg  = rs2;
      r.immediate = imm;
      return r;
   endfunction

   function automatic req_type random_req();
      int          edges[16] = '{-4097, -4096, -4095, -2049, -2048, -2047, -1, 0,
                                 1, 2046, 2047, 2048, 4094, 4095, 4096, 32'h7FFF_FFFF};
      logic [31:0] rnd;
      int          v;
      req_type     r;
      rnd = ($urandom_range(99) < 6) ? $urandom_range(63, 42) : $urandom_range(41, 0);
      r.mode = rnd[5:0];
      rnd = $urandom();
      r.dest_reg = rnd[4:0];
      r.src1_reg = rnd[9:5];
      r.src2_reg = rnd[14:10];
      case ($urandom_range(9))
         0, 1, 2: v = int'($urandom_range(4095)) - 2048;
         3, 4:    v = int'($urandom_range(8191)) - 4096;
         5, 6:    v = edges[$urandom_range(15)];
         7:       v = int'($urandom_range(31)) - 16;
         default: v = int'($urandom());
      endcase
      r.immediate = v;
      return r;
   endfunction

   task automatic drive_item(input req_type r, input int unsigned gap_pct);
      while ($urandom_range(99) < gap_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   initial begin
      int unsigned gap_pct[3] = '{0, 50, 9};
      reset    = 1'b1;
      start    = 1'b0;
      req_data = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      drive_item(make_req(OP_ADD, 31, 31, 31, -1), 0);
      drive_item(make_req(OP_SUB, 0, 0, 0, 0), 0);
      drive_item(make_req(OP_SRA, 5, 10, 15, 99), 0);
      drive_item(make_req(OP_ADDI, 1, 2, 3, 2047), 0);
      drive_item(make_req(OP_ADDI, 31, 31, 0, -2048), 0);
      drive_item(make_req(OP_XORI, 1, 2, 3, 2048), 0);
      drive_item(make_req(OP_ANDI, 1, 2, 3, -2049), 0);
      drive_item(make_req(OP_SRAI, 3, 4, 0, 31), 0);
      drive_item(make_req(OP_SRAI, 3, 4, 0, -1), 0);
      drive_item(make_req(OP_JALR, 31, 31, 31, -2048), 0);
      drive_item(make_req(OP_LW, 7, 8, 9, -1), 0);
      drive_item(make_req(OP_SW, 31, 1, 0, 2047), 0);
      drive_item(make_req(OP_SB, 0, 31, 31, -2048), 0);
      drive_item(make_req(OP_SH, 3, 3, 3, 2048), 0);
      drive_item(make_req(OP_BEQ, 0, 31, 31, 4095), 0);
      drive_item(make_req(OP_BNE, 9, 1, 2, -4096), 0);
      drive_item(make_req(OP_BGE, 0, 1, 2, 4096), 0);
      drive_item(make_req(OP_BLTU, 0, 1, 2, -4097), 0);
      drive_item(make_req(OP_JAL, 31, 0, 0, 32'h7FFF_FFFF), 0);
      drive_item(make_req(OP_JAL, 1, 5, 5, 32'h8000_0000), 0);
      drive_item(make_req(OP_LUI, 31, 31, 31, -1), 0);
      drive_item(make_req(OP_AUIPC, 0, 7, 7, 32'h1234_5678), 0);
      drive_item(make_req(OP_ECALL, 31, 31, 31, -1), 0);
      drive_item(make_req(OP_EBREAK, 31, 31, 31, -1), 0);
      drive_item(make_req(6'd42, 1, 2, 3, 4), 0);
      drive_item(make_req(6'd63, 31, 31, 31, -1), 0);
      drive_item(make_req(OP_REM, 31, 31, 31, 0), 0);

      // the response side has no hold-off, so only request gaps vary
      for (int p = 0; p < 3; p++) begin
         for (int unsigned n = 0; n < ITEMS_PER_PHASE; n++) drive_item(random_req(), gap_pct[p]);
      end
      start <= 1'b0;

      while (sb.pending.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);

      $display("Encoded %0d items over %0d distinct selectors, %0d of them range errors.",
               sb.encoded, $countones(sb.selectors_seen), sb.range_errors);
      $display("Request gaps of 0, 50 and 9 percent; %0d mismatches.", sb.errors);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule

// ===== filelist.f =====
hw/rtl/rvenc_pkg.sv
hw/rtl/rvenc_encode.sv
hw/rtl/rv32im_instruction_encoder_top.sv
tb/sv/tb_rv32im_instruction_encoder_top.sv
